@@ design/targa_rle_pixel_decoder_macros.svh @@
// Assertion macros for the Targa RLE pixel decoder.
// Included by the top level; no other dependencies.
`ifndef TARGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TARGA_RLE_PIXEL_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define TRD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("decoder check failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted (active low).
`define TRD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("decoder check failed (next cycle)");

`endif

@@ design/trd_pkg.sv @@
// Shared types and constants for the Targa RLE pixel decoder.
// Used by trd_unpack, trd_emit and targa_rle_pixel_decoder; no dependencies.
`timescale 1ns / 1ps

package trd_pkg;

    localparam int unsigned MAX_PIXELS_DEF = 16777216;

    localparam int BYTE_W      = 8;
    localparam int PIX_W       = 32;
    localparam int CNT_FIELD_W = 2;
    localparam int POS_W       = 24;
    localparam int TOTAL_W     = 25;
    localparam int BPP_W       = 3;
    localparam int PKT_W       = 8;
    localparam int SLOT_W      = 2;
    localparam int USER_W      = 2;

    localparam int TDATA_BITS  = 2 * PIX_W + CNT_FIELD_W + POS_W;
    localparam int TDATA_W     = ((TDATA_BITS + 7) / 8) * 8;
    localparam int PAD_W       = TDATA_W - TDATA_BITS;

    // Packet header: bit 7 marks a run packet, bits 6..0 hold count minus one
    localparam int RUN_FLAG_BIT = 7;
    localparam int HDR_CNT_W    = 7;

    // Pixel sizes in bytes
    localparam logic [BPP_W-1:0] BPP_FOUR = 3'd4;

    typedef enum logic [1:0] {
        CFG_BPP   = 2'd0,
        CFG_RLE   = 2'd1,
        CFG_TOTAL = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SETUP = 2'd1,
        ST_CALC  = 2'd2,
        ST_EMIT  = 2'd3
    } emit_state_t;

    typedef struct packed {
        logic bpp4;
        logic rle;
    } fmt_cfg_t;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pixel;
        logic             is_run;
        logic [PKT_W-1:0] run_cnt;
        logic             more_left;
    } pix_evt_t;

    typedef struct packed {
        logic [PIX_W-1:0]       pixel_first;
        logic [PIX_W-1:0]       pixel_second;
        logic [CNT_FIELD_W-1:0] pixel_count;
        logic [POS_W-1:0]       pixel_position;
        logic                   run_last;
        logic                   image_done;
        logic                   overrun;
    } beat_t;

endpackage

@@ design/targa_rle_pixel_decoder.sv @@
// A header byte or a byte inside a pixel is taken with no result.
// A byte that completes a pixel passes the setup, run size and emit states and the output
// register to its first beat on m_tvalid, then one beat per cycle while m_tready is high.
// Throughput: 1 byte per cycle, except a pixel-completing byte holds s_tready low until the
// sequencer is idle again, stalls included; the shared adder steps up to two pixels a beat.
// Reset: synchronous aresetn clears decoder state, bpp 4, RLE on, total MAX_PIXELS.
`timescale 1ns / 1ps

`include "targa_rle_pixel_decoder_macros.svh"

module targa_rle_pixel_decoder #(
    parameter int unsigned MAX_PIXELS = trd_pkg::MAX_PIXELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Input stream: one image data byte per beat
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [trd_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_byte

    // Result stream: up to two pixels per beat
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] pixel_first, [63:32] pixel_second, [65:64] pixel_count,
    // [89:66] pixel_position, [95:90] zero
    output logic [trd_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tlast,   // run_last
    output logic [trd_pkg::USER_W-1:0]    m_tuser,   // [0] image_done, [1] overrun

    // Configuration write port
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [trd_pkg::TOTAL_W-1:0]   cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_PIXELS + 1);

    // Configuration, held pre-clamped: pixel size as a 4-byte flag, total in range
    logic                 bpp4_reg, bpp4_next;
    logic                 rle_reg, rle_next;
    logic [CNT_W-1:0]     total_reg, total_next;

    trd_pkg::fmt_cfg_t    fmt_cfg;
    trd_pkg::pix_evt_t    evt;
    trd_pkg::beat_t       beat;
    logic                 beat_valid;
    logic                 emit_idle;
    logic                 restart;
    logic                 byte_acc;
    logic                 out_free;

    // Output register
    logic                 m_valid_reg, m_valid_next;
    trd_pkg::beat_t       m_beat_reg, m_beat_next;

    // Position of the held beat lies inside the configured image
    logic                 pos_in_image;

    // ---------------------------------------------------------------
    // Configuration registers; clamp on write so the datapath sees
    // only legal sizes and totals
    // ---------------------------------------------------------------
    always_comb begin
        bpp4_next  = bpp4_reg;
        rle_next   = rle_reg;
        total_next = total_reg;
        if (cfg_we) begin
            case (cfg_index)
                trd_pkg::CFG_BPP: begin
                    bpp4_next = (cfg_wdata[trd_pkg::BPP_W-1:0] >= trd_pkg::BPP_FOUR);
                end
                trd_pkg::CFG_RLE: begin
                    rle_next = cfg_wdata[0];
                end
                trd_pkg::CFG_TOTAL: begin
                    if (cfg_wdata == '0) begin
                        total_next = CNT_W'(1);
                    end else if (cfg_wdata > trd_pkg::TOTAL_W'(MAX_PIXELS)) begin
                        total_next = CNT_W'(MAX_PIXELS);
                    end else begin
                        total_next = CNT_W'(cfg_wdata);
                    end
                end
                default: begin
                    // Index past the register list: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp4_reg  <= 1'b1;
            rle_reg   <= 1'b1;
            total_reg <= CNT_W'(MAX_PIXELS);
        end else begin
            bpp4_reg  <= bpp4_next;
            rle_reg   <= rle_next;
            total_reg <= total_next;
        end
    end

    assign fmt_cfg.bpp4 = bpp4_reg;
    assign fmt_cfg.rle  = rle_reg;

    // ---------------------------------------------------------------
    // Input side: take bytes only while the sequencer is idle
    // ---------------------------------------------------------------
    assign s_tready = emit_idle;
    assign byte_acc = s_tvalid && s_tready;

    trd_unpack u_unpack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .byte_acc (byte_acc),
        .byte_in  (s_tdata),
        .cfg      (fmt_cfg),
        .restart  (restart),
        .evt      (evt)
    );

    // ---------------------------------------------------------------
    // Result sequencer; emit a beat only when the output register frees up
    // ---------------------------------------------------------------
    assign out_free = !m_valid_reg || m_tready;

    trd_emit #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .evt        (evt),
        .total      (total_reg),
        .out_free   (out_free),
        .idle       (emit_idle),
        .beat_valid (beat_valid),
        .beat       (beat),
        .restart    (restart)
    );

    // ---------------------------------------------------------------
    // Output register: load a new beat when free, hold while stalled
    // ---------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        m_beat_next  = m_beat_reg;
        if (beat_valid) begin
            m_valid_next = 1'b1;
            m_beat_next  = beat;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_beat_reg <= m_beat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{trd_pkg::PAD_W{1'b0}},
                       m_beat_reg.pixel_position,
                       m_beat_reg.pixel_count,
                       m_beat_reg.pixel_second,
                       m_beat_reg.pixel_first};
    assign m_tlast  = m_beat_reg.run_last;
    assign m_tuser  = {m_beat_reg.overrun, m_beat_reg.image_done};

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    assign pos_in_image = (trd_pkg::TOTAL_W'(m_beat_reg.pixel_position)
                           < trd_pkg::TOTAL_W'(total_reg));

    // Image end only ever lands on the closing beat of a byte
    `TRD_ASSERT_NOW(a_done_on_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast)
    // Dropped pixels are flagged only on the image's final beat
    `TRD_ASSERT_NOW(a_over_with_done, aclk, aresetn, m_tvalid && m_tuser[1], m_tuser[0])
    // Reported positions stay inside the configured image
    `TRD_ASSERT_NOW(a_pos_in_range, aclk, aresetn, m_tvalid, pos_in_image)
    // A stalled beat holds its data until it is taken
    `TRD_ASSERT_NXT(a_hold_beat, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

@@ design/trd_unpack.sv @@
// Packet header parsing and pixel byte gathering for the Targa RLE decoder.
// Depends on trd_pkg.
`timescale 1ns / 1ps

module trd_unpack (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        byte_acc,
    input  logic [trd_pkg::BYTE_W-1:0]  byte_in,
    input  trd_pkg::fmt_cfg_t           cfg,
    input  logic                        restart,
    output trd_pkg::pix_evt_t           evt
);

    logic                         expect_hdr_reg, expect_hdr_next;
    logic                         run_pkt_reg, run_pkt_next;
    logic [trd_pkg::PKT_W-1:0]    pkt_left_reg, pkt_left_next;
    logic [trd_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [trd_pkg::PIX_W-1:0]    gather_reg, gather_next;

    logic [trd_pkg::PIX_W-1:0]    gather_or;
    logic [trd_pkg::PKT_W-1:0]    left_eff;
    logic [trd_pkg::PKT_W-1:0]    left_dec;
    logic [trd_pkg::SLOT_W-1:0]   last_slot;

    assign gather_or = gather_reg | (trd_pkg::PIX_W'(byte_in) << {slot_reg, 3'b000});
    // An empty count (only after a mode switch) acts as one
    assign left_eff  = (pkt_left_reg == '0) ? trd_pkg::PKT_W'(1) : pkt_left_reg;
    assign left_dec  = left_eff - trd_pkg::PKT_W'(1);
    assign last_slot = cfg.bpp4 ? trd_pkg::SLOT_W'(3) : trd_pkg::SLOT_W'(2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_hdr_reg <= 1'b1;
            run_pkt_reg    <= 1'b0;
            pkt_left_reg   <= '0;
            slot_reg       <= '0;
            gather_reg     <= '0;
        end else begin
            expect_hdr_reg <= expect_hdr_next;
            run_pkt_reg    <= run_pkt_next;
            pkt_left_reg   <= pkt_left_next;
            slot_reg       <= slot_next;
            gather_reg     <= gather_next;
        end
    end

    always_comb begin
        expect_hdr_next = expect_hdr_reg;
        run_pkt_next    = run_pkt_reg;
        pkt_left_next   = pkt_left_reg;
        slot_next       = slot_reg;
        gather_next     = gather_reg;
        evt             = '0;

        if (restart) begin
            expect_hdr_next = 1'b1;
            pkt_left_next   = '0;
            slot_next       = '0;
            gather_next     = '0;
        end else if (byte_acc) begin
            if (cfg.rle && expect_hdr_reg) begin
                run_pkt_next    = byte_in[trd_pkg::RUN_FLAG_BIT];
                pkt_left_next   = trd_pkg::PKT_W'(byte_in[trd_pkg::HDR_CNT_W-1:0])
                                  + trd_pkg::PKT_W'(1);
                expect_hdr_next = 1'b0;
                slot_next       = '0;
                gather_next     = '0;
            end else if (slot_reg < last_slot) begin
                gather_next = gather_or;
                slot_next   = slot_reg + trd_pkg::SLOT_W'(1);
            end else begin
                gather_next = '0;
                slot_next   = '0;
                evt.valid   = 1'b1;
                evt.pixel   = gather_or;
                if (cfg.rle && run_pkt_reg) begin
                    evt.is_run      = 1'b1;
                    evt.run_cnt     = left_eff;
                    pkt_left_next   = '0;
                    expect_hdr_next = 1'b1;
                end else if (cfg.rle) begin
                    pkt_left_next = left_dec;
                    evt.more_left = (left_dec != '0);
                    if (left_dec == '0) begin
                        expect_hdr_next = 1'b1;
                    end
                end
            end
        end
    end

endmodule

@@ design/trd_emit.sv @@
// Result sequencer for the Targa RLE decoder: one shared position adder
// stepped once per beat, up to two pixels at a time. Depends on trd_pkg.
`timescale 1ns / 1ps

module trd_emit #(
    parameter int unsigned MAX_PIXELS = trd_pkg::MAX_PIXELS_DEF,
    localparam int CNT_W = $clog2(MAX_PIXELS + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  trd_pkg::pix_evt_t   evt,
    input  logic [CNT_W-1:0]    total,
    input  logic                out_free,
    output logic                idle,
    output logic                beat_valid,
    output trd_pkg::beat_t      beat,
    output logic                restart
);

    localparam int CMP_W = (CNT_W > trd_pkg::PKT_W) ? CNT_W : trd_pkg::PKT_W;

    trd_pkg::emit_state_t          state_reg, state_next;
    logic [trd_pkg::PIX_W-1:0]     pix_reg, pix_next;
    logic                          run_reg, run_next;
    logic [trd_pkg::PKT_W-1:0]     cnt_reg, cnt_next;
    logic                          more_reg, more_next;
    logic [CNT_W-1:0]              emitted_reg, emitted_next;
    logic [CNT_W-1:0]              rem_reg, rem_next;
    logic [trd_pkg::PKT_W-1:0]     take_reg, take_next;
    logic                          done_reg, done_next;
    logic                          over_reg, over_next;

    logic                          two_pix;
    logic                          last_beat;
    logic [CNT_W-1:0]              step;
    logic [CNT_W-1:0]              pos_sum;
    logic [CNT_W-1:0]              base;
    logic [CMP_W-1:0]              cnt_c;
    logic [CMP_W-1:0]              rem_c;

    assign two_pix   = (take_reg >= trd_pkg::PKT_W'(2));
    assign last_beat = (take_reg <= trd_pkg::PKT_W'(2));
    assign step      = two_pix ? CNT_W'(2) : CNT_W'(1);
    assign pos_sum   = emitted_reg + step;
    // A total lowered below progress restarts the position first
    assign base      = (emitted_reg >= total) ? '0 : emitted_reg;
    assign cnt_c     = CMP_W'(cnt_reg);
    assign rem_c     = CMP_W'(rem_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= trd_pkg::ST_IDLE;
            emitted_reg <= '0;
        end else begin
            state_reg   <= state_next;
            emitted_reg <= emitted_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg  <= pix_next;
        run_reg  <= run_next;
        cnt_reg  <= cnt_next;
        more_reg <= more_next;
        rem_reg  <= rem_next;
        take_reg <= take_next;
        done_reg <= done_next;
        over_reg <= over_next;
    end

    always_comb begin
        state_next   = state_reg;
        pix_next     = pix_reg;
        run_next     = run_reg;
        cnt_next     = cnt_reg;
        more_next    = more_reg;
        emitted_next = emitted_reg;
        rem_next     = rem_reg;
        take_next    = take_reg;
        done_next    = done_reg;
        over_next    = over_reg;
        idle         = 1'b0;
        beat_valid   = 1'b0;
        restart      = 1'b0;

        beat.pixel_first    = pix_reg;
        beat.pixel_second   = two_pix ? pix_reg : '0;
        beat.pixel_count    = two_pix ? trd_pkg::CNT_FIELD_W'(2) : trd_pkg::CNT_FIELD_W'(1);
        beat.pixel_position = trd_pkg::POS_W'(emitted_reg);
        beat.run_last       = last_beat;
        beat.image_done     = last_beat & done_reg;
        beat.overrun        = last_beat & over_reg;

        case (state_reg)
            trd_pkg::ST_IDLE: begin
                idle = 1'b1;
                if (evt.valid) begin
                    pix_next   = evt.pixel;
                    run_next   = evt.is_run;
                    cnt_next   = evt.run_cnt;
                    more_next  = evt.more_left;
                    state_next = trd_pkg::ST_SETUP;
                end
            end
            trd_pkg::ST_SETUP: begin
                emitted_next = base;
                rem_next     = total - base;
                state_next   = trd_pkg::ST_CALC;
            end
            trd_pkg::ST_CALC: begin
                if (run_reg) begin
                    done_next = (cnt_c >= rem_c);
                    over_next = (cnt_c > rem_c);
                    take_next = (cnt_c >= rem_c) ? trd_pkg::PKT_W'(rem_reg) : cnt_reg;
                end else begin
                    done_next = (rem_reg == CNT_W'(1));
                    over_next = (rem_reg == CNT_W'(1)) && more_reg;
                    take_next = trd_pkg::PKT_W'(1);
                end
                state_next = trd_pkg::ST_EMIT;
            end
            trd_pkg::ST_EMIT: begin
                if (out_free) begin
                    beat_valid   = 1'b1;
                    emitted_next = pos_sum;
                    take_next    = take_reg - trd_pkg::PKT_W'(step);
                    if (last_beat) begin
                        state_next = trd_pkg::ST_IDLE;
                        if (done_reg) begin
                            emitted_next = '0;
                            restart      = 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = trd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
